// ===== src/dowc_pkg.sv =====
// types and constants shared by the dop window outdoor classifier
// no dependencies
package dowc_pkg;

  localparam int unsigned DopW    = 11;
  localparam int unsigned MinW    = 3;
  localparam int unsigned SlotsW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DopW-1:0]   DopReset         = 11'd1598;
  localparam logic [DopW-1:0]   ValidLimitReset  = 11'd800;
  localparam logic [DopW-1:0]   HdopLimitReset   = 11'd40;
  localparam logic [DopW-1:0]   PdopLimitReset   = 11'd80;
  localparam logic [MinW-1:0]   MinValidReset    = 3'd3;
  localparam logic [SlotsW-1:0] ValidSlotsMax    = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VALID_LIMIT = 2'd0,
    CFG_HDOP_LIMIT  = 2'd1,
    CFG_PDOP_LIMIT  = 2'd2,
    CFG_MIN_VALID   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [DopW-1:0] hdop_sample;
    logic [DopW-1:0] pdop_sample;
  } in_item_t;

  typedef struct packed {
    logic              outdoor;
    logic [SlotsW-1:0] valid_slots;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

// ===== src/dop_window_outdoor_classifier.sv =====
// Outdoor classifier over a window of GNSS DOP samples. Each transfer on the
// input writes one HDOP/PDOP pair (units of 1/16) into a ring of the last
// WINDOW pairs, then the block walks the ring one slot per cycle, summing the
// slots whose values are both below valid_limit, and reports outdoor when
// enough slots are valid and both averages are under their limits. An
// item goes through the input transfer, the scan of the WINDOW slots and
// the load of the result register, which waits while an older result is
// held by out_stall. The next item is taken while a result still waits on
// the output. The rings come out of reset at 99.875 in every slot; config
// writes take effect at once and belong while the block is idle.
// depends on dowc_pkg, dowc_ctrl, dowc_dpath
module dop_window_outdoor_classifier #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dowc_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dowc_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  dowc_pkg::cfg_index_t  cfg_index,
  input  logic [10:0]           cfg_data
);
  import dowc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dowc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  dowc_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

  // busy right after an input transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while scan not started");

  // a fresh result only follows a scan
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded without a scan");

  // outdoor needs at least one valid slot
  a_outdoor_needs_slots: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.outdoor) |-> (out_data.valid_slots != '0))
    else $error("outdoor reported with no valid slot");

endmodule

// ===== src/dowc_ctrl.sv =====
// controller state machine: input transfer, slot scan, result hand-off
// depends on dowc_pkg
module dowc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dowc_pkg::ctrl_cmd_t    cmd,
  input  dowc_pkg::dp_status_t   status
);
  import dowc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/dowc_dpath.sv =====
// datapath: config registers, sample rings, scan accumulators, decision
// depends on dowc_pkg
module dowc_dpath #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  dowc_pkg::cfg_index_t   cfg_index,
  input  logic [10:0]            cfg_data,
  input  dowc_pkg::in_item_t     in_data,
  output dowc_pkg::out_item_t    out_data,
  input  dowc_pkg::ctrl_cmd_t    cmd,
  output dowc_pkg::dp_status_t   status
);
  import dowc_pkg::*;

  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned SumW = DopW + CntW;
  localparam int unsigned CmpW = CntW + MinW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);

  logic [DopW-1:0] valid_limit;
  logic [DopW-1:0] hdop_limit;
  logic [DopW-1:0] pdop_limit;
  logic [MinW-1:0] min_valid;

  logic [DopW-1:0] hdop_ring [WINDOW];
  logic [DopW-1:0] pdop_ring [WINDOW];
  logic [IdxW-1:0] write_slot;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] cnt;
  logic [SumW-1:0] hsum;
  logic [SumW-1:0] psum;

  logic            slot_ok;
  logic [SumW-1:0] hprod;
  logic [SumW-1:0] pprod;
  logic [CmpW-1:0] cnt_x;
  logic            outdoor_next;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_limit <= ValidLimitReset;
      hdop_limit  <= HdopLimitReset;
      pdop_limit  <= PdopLimitReset;
      min_valid   <= MinValidReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VALID_LIMIT: valid_limit <= cfg_data;
        CFG_HDOP_LIMIT:  hdop_limit  <= cfg_data;
        CFG_PDOP_LIMIT:  pdop_limit  <= cfg_data;
        CFG_MIN_VALID:   min_valid   <= cfg_data[MinW-1:0];
        default: ;
      endcase
    end
  end

  // sample rings
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        hdop_ring[i] <= DopReset;
        pdop_ring[i] <= DopReset;
      end
      write_slot <= '0;
    end else if (cmd.accept) begin
      hdop_ring[write_slot] <= in_data.hdop_sample;
      pdop_ring[write_slot] <= in_data.pdop_sample;
      write_slot <= (write_slot == LastIdx) ? '0 : write_slot + 1'b1;
    end
  end

  // one slot per cycle
  assign slot_ok = (hdop_ring[idx] < valid_limit) && (pdop_ring[idx] < valid_limit);
  assign status.scan_last = (idx == LastIdx);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx  <= '0;
      cnt  <= '0;
      hsum <= '0;
      psum <= '0;
    end else if (cmd.scan) begin
      if (!status.scan_last) begin
        idx <= idx + 1'b1;
      end
      if (slot_ok) begin
        cnt  <= cnt + 1'b1;
        hsum <= hsum + SumW'(hdop_ring[idx]);
        psum <= psum + SumW'(pdop_ring[idx]);
      end
    end
  end

  // average test as sum < limit * count
  assign hprod = SumW'(hdop_limit) * SumW'(cnt);
  assign pprod = SumW'(pdop_limit) * SumW'(cnt);
  assign cnt_x = CmpW'(cnt);
  assign outdoor_next = (cnt != '0) && (cnt_x >= CmpW'(min_valid)) &&
                        (hsum < hprod) && (psum < pprod);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.outdoor     <= outdoor_next;
      out_data.valid_slots <= (cnt_x > CmpW'(ValidSlotsMax)) ? ValidSlotsMax
                                                             : cnt_x[SlotsW-1:0];
    end
  end

endmodule
